/* rtl/bike_controller_serializer_unit_defines.svh */
// ----------------------------------------------------------------------------
// bike controller serializer: assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef BIKE_CONTROLLER_SERIALIZER_UNIT_DEFINES_SVH
`define BIKE_CONTROLLER_SERIALIZER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcs assertion failed");

// next-cycle implication, disabled in reset
`define BCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcs assertion failed");

`endif

/* rtl/bcs_pkg.sv */
// ----------------------------------------------------------------------------
// bcs_pkg
// shared types and constants of the bike controller serializer
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_STROBE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [2:0] REG_STEER_LIMIT    = 3'd0;
  localparam logic [2:0] REG_BRAKE_LIMIT    = 3'd1;
  localparam logic [2:0] REG_THROTTLE_LIMIT = 3'd2;
  localparam logic [2:0] REG_ZONE_LOW       = 3'd3;
  localparam logic [2:0] REG_ZONE_MID       = 3'd4;
  localparam logic [2:0] REG_ZONE_HIGH      = 3'd5;

  localparam logic [6:0] STEER_LIMIT_RST    = 7'd20;
  localparam logic [6:0] BRAKE_LIMIT_RST    = 7'd20;
  localparam logic [6:0] THROTTLE_LIMIT_RST = 7'd20;
  localparam logic [6:0] ZONE_LOW_RST       = 7'd1;
  localparam logic [6:0] ZONE_MID_RST       = 7'd8;
  localparam logic [6:0] ZONE_HIGH_RST      = 7'd15;

  localparam logic [6:0] BRAKE_SHOW_LEVEL = 7'd8;

  localparam int WORD_A_W = 12;
  localparam int WORD_B_W = 11;

  typedef struct packed {
    logic [6:0] steer_limit;
    logic [6:0] brake_limit;
    logic [6:0] throttle_limit;
    logic [6:0] zone_low;
    logic [6:0] zone_mid;
    logic [6:0] zone_high;
  } cfg_t;

  typedef struct packed {
    logic attached;
    logic left;
    logic right;
    logic brake;
    logic throttle;
    logic shift;
    logic rear;
    logic select;
    logic start;
  } buttons_t;

endpackage

/* rtl/bcs_frame.sv */
// ----------------------------------------------------------------------------
// bcs_frame
// frame tick logic: steering and level ramps, button latch, frame words
// ----------------------------------------------------------------------------
module bcs_frame (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  bcs_pkg::buttons_t             btn,
  input  bcs_pkg::cfg_t                 cfg,
  output logic [bcs_pkg::WORD_A_W-1:0]  word_a,
  output logic [bcs_pkg::WORD_B_W-1:0]  word_b
);

  logic signed [7:0] steer_position, steer_position_next;
  logic [6:0] brake_level, brake_level_next;
  logic [6:0] throttle_level, throttle_level_next;
  logic [7:0] button_latch, button_latch_next;
  logic [bcs_pkg::WORD_A_W-1:0] word_a_next;
  logic [bcs_pkg::WORD_B_W-1:0] word_b_next;

  logic left_eff, right_eff;
  logic signed [8:0] pos9, lim9, zl9, zm9, zh9;
  logic right_far, left_far, right_fine, left_fine;
  logic brake_shown;
  logic [1:0] thr_code, brk_code;

  // 3 above high, 2 above mid, 1 above low, 0 none
  function automatic logic [1:0] zone_code(input logic [6:0] v, input bcs_pkg::cfg_t c);
    logic [1:0] code;
    if (v > c.zone_high) code = 2'd3;
    else if (v > c.zone_mid) code = 2'd2;
    else if (v > c.zone_low) code = 2'd1;
    else code = 2'd0;
    return code;
  endfunction

  always_comb begin
    left_eff  = btn.left & ~btn.right;
    right_eff = btn.right & ~btn.left;
    pos9 = 9'(steer_position);
    lim9 = signed'({2'b00, cfg.steer_limit});

    steer_position_next = steer_position;
    if (!left_eff && !right_eff) begin
      if (steer_position > 8'sd0) steer_position_next = steer_position - 8'sd1;
      else if (steer_position < 8'sd0) steer_position_next = steer_position + 8'sd1;
    end else if (left_eff) begin
      if (pos9 > -lim9) steer_position_next = steer_position - 8'sd1;
    end else begin
      if (pos9 < lim9) steer_position_next = steer_position + 8'sd1;
    end

    brake_level_next = brake_level;
    if (btn.brake) begin
      if (brake_level < cfg.brake_limit) brake_level_next = brake_level + 7'd1;
    end else if (brake_level != 7'd0) begin
      brake_level_next = brake_level - 7'd1;
    end

    throttle_level_next = throttle_level;
    if (btn.throttle) begin
      if (throttle_level < cfg.throttle_limit) throttle_level_next = throttle_level + 7'd1;
    end else if (throttle_level != 7'd0) begin
      throttle_level_next = throttle_level - 7'd1;
    end

    // bit 7 gear flag, bit 6 shift held
    button_latch_next = {button_latch[7:6], 6'b0};
    if (btn.shift) begin
      if (!button_latch[6]) button_latch_next[7:6] = {~button_latch[7], 1'b1};
    end else begin
      button_latch_next[6] = 1'b0;
    end
    button_latch_next[0] = btn.rear;
    button_latch_next[4] = btn.select;
    button_latch_next[5] = btn.start;

    pos9 = 9'(steer_position_next);
    zl9  = signed'({2'b00, cfg.zone_low});
    zm9  = signed'({2'b00, cfg.zone_mid});
    zh9  = signed'({2'b00, cfg.zone_high});
    right_far  = 1'b0;
    left_far   = 1'b0;
    right_fine = 1'b0;
    left_fine  = 1'b0;
    if (pos9 > 9'sd0) begin
      if (pos9 > zh9) begin
        right_far  = 1'b1;
        right_fine = 1'b1;
      end else if (pos9 > zm9) begin
        right_far = 1'b1;
      end else if (pos9 > zl9) begin
        right_fine = 1'b1;
      end
    end else begin
      if (pos9 < -zh9) begin
        left_far  = 1'b1;
        left_fine = 1'b1;
      end else if (pos9 < -zm9) begin
        left_far = 1'b1;
      end else if (pos9 < -zl9) begin
        left_fine = 1'b1;
      end
    end

    brake_shown = !(throttle_level_next > bcs_pkg::BRAKE_SHOW_LEVEL ||
                    brake_level_next < bcs_pkg::BRAKE_SHOW_LEVEL);
    thr_code = zone_code(throttle_level_next, cfg);
    brk_code = zone_code(brake_level_next, cfg);

    word_a_next = {button_latch_next[0], button_latch_next[7], brake_shown,
                   left_fine, right_fine, left_far, right_far, 5'b00000};

    word_b_next = '0;
    word_b_next[10] = button_latch_next[5];
    word_b_next[9]  = button_latch_next[4];
    if (brake_shown) begin
      word_b_next[4] = (brk_code == 2'd3);
      word_b_next[5] = (brk_code == 2'd2);
      word_b_next[6] = (brk_code == 2'd1);
    end else begin
      word_b_next[3] = (thr_code == 2'd3);
      word_b_next[7] = (thr_code == 2'd2);
      word_b_next[8] = (thr_code == 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_position <= '0;
      brake_level    <= '0;
      throttle_level <= '0;
      button_latch   <= '0;
      word_a         <= '0;
      word_b         <= '0;
    end else if (tick) begin
      if (!btn.attached) begin
        steer_position <= '0;
        brake_level    <= '0;
        throttle_level <= '0;
        button_latch   <= '0;
        word_a         <= '0;
        word_b         <= '0;
      end else begin
        steer_position <= steer_position_next;
        brake_level    <= brake_level_next;
        throttle_level <= throttle_level_next;
        button_latch   <= button_latch_next;
        word_a         <= word_a_next;
        word_b         <= word_b_next;
      end
    end
  end

endmodule

/* rtl/bike_controller_serializer_unit.sv */
// ----------------------------------------------------------------------------
// bike_controller_serializer_unit: one item per cycle while item_ready; a frame
// tick or strobe updates state at its accept edge, a read result is registered
// then and visible next cycle; ready falls only while a result waits unread;
// synchronous reset clears state and loads register defaults, no clearing pass
// ----------------------------------------------------------------------------
module bike_controller_serializer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  command,
  input  logic        attached,
  input  logic        press_left,
  input  logic        press_right,
  input  logic        press_brake,
  input  logic        press_throttle,
  input  logic        press_shift,
  input  logic        press_rear,
  input  logic        press_select,
  input  logic        press_start,
  input  logic        strobe_value,
  input  logic        port_chosen,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [4:0]  read_bits
);

  bcs_pkg::cfg_t cfg;
  bcs_pkg::buttons_t btn;
  logic [bcs_pkg::WORD_A_W-1:0] word_a, shift_reg_a;
  logic [bcs_pkg::WORD_B_W-1:0] word_b, shift_reg_b;
  logic strobe_level;
  logic accept, cfg_write;
  logic [2:0] reg_index;

  assign pready     = 1'b1;
  assign reg_index  = paddr[4:2];
  assign cfg_write  = psel && penable && pwrite && pready;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steer_limit    <= bcs_pkg::STEER_LIMIT_RST;
      cfg.brake_limit    <= bcs_pkg::BRAKE_LIMIT_RST;
      cfg.throttle_limit <= bcs_pkg::THROTTLE_LIMIT_RST;
      cfg.zone_low       <= bcs_pkg::ZONE_LOW_RST;
      cfg.zone_mid       <= bcs_pkg::ZONE_MID_RST;
      cfg.zone_high      <= bcs_pkg::ZONE_HIGH_RST;
    end else if (cfg_write) begin
      case (reg_index)
        bcs_pkg::REG_STEER_LIMIT:    cfg.steer_limit    <= pwdata[6:0];
        bcs_pkg::REG_BRAKE_LIMIT:    cfg.brake_limit    <= pwdata[6:0];
        bcs_pkg::REG_THROTTLE_LIMIT: cfg.throttle_limit <= pwdata[6:0];
        bcs_pkg::REG_ZONE_LOW:       cfg.zone_low       <= pwdata[6:0];
        bcs_pkg::REG_ZONE_MID:       cfg.zone_mid       <= pwdata[6:0];
        bcs_pkg::REG_ZONE_HIGH:      cfg.zone_high      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      bcs_pkg::REG_STEER_LIMIT:    prdata = 32'(cfg.steer_limit);
      bcs_pkg::REG_BRAKE_LIMIT:    prdata = 32'(cfg.brake_limit);
      bcs_pkg::REG_THROTTLE_LIMIT: prdata = 32'(cfg.throttle_limit);
      bcs_pkg::REG_ZONE_LOW:       prdata = 32'(cfg.zone_low);
      bcs_pkg::REG_ZONE_MID:       prdata = 32'(cfg.zone_mid);
      bcs_pkg::REG_ZONE_HIGH:      prdata = 32'(cfg.zone_high);
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    btn.attached = attached;
    btn.left     = press_left;
    btn.right    = press_right;
    btn.brake    = press_brake;
    btn.throttle = press_throttle;
    btn.shift    = press_shift;
    btn.rear     = press_rear;
    btn.select   = press_select;
    btn.start    = press_start;
  end

  bcs_frame u_frame (
    .clk    (clk),
    .rst    (rst),
    .tick   (accept && command == bcs_pkg::CMD_TICK),
    .btn    (btn),
    .cfg    (cfg),
    .word_a (word_a),
    .word_b (word_b)
  );

  // strobe and shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_level <= 1'b0;
      shift_reg_a  <= '0;
      shift_reg_b  <= '0;
    end else if (accept) begin
      if (command == bcs_pkg::CMD_STROBE) begin
        strobe_level <= strobe_value;
        if (strobe_level && !strobe_value) begin
          shift_reg_a <= word_a;
          shift_reg_b <= word_b;
        end
      end else if (command == bcs_pkg::CMD_READ && port_chosen) begin
        shift_reg_a <= shift_reg_a >> 1;
        shift_reg_b <= shift_reg_b >> 1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && command == bcs_pkg::CMD_READ) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && command == bcs_pkg::CMD_READ) begin
      read_bits <= port_chosen ? {shift_reg_a[4], shift_reg_b[3], 3'b000} : 5'b00000;
    end
  end

endmodule

/* rtl/bcs_checker.sv */
// ----------------------------------------------------------------------------
// bcs_checker
// port-level checks of the bike controller serializer, bound to the top level
// ----------------------------------------------------------------------------
`include "bike_controller_serializer_unit_defines.svh"

module bcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic [1:0] command,
  input logic       port_chosen,
  input logic       result_valid,
  input logic       result_ready,
  input logic [4:0] read_bits
);

  logic port_zero_read, other_taken, result_stalled;

  assign port_zero_read = item_valid && item_ready && command == bcs_pkg::CMD_READ &&
                          !port_chosen;
  assign other_taken    = item_valid && item_ready && command != bcs_pkg::CMD_READ;
  assign result_stalled = result_valid && !result_ready;

  `BCS_ASSERT_NOW(a_bits_shape, clk, rst, result_valid, read_bits[2:0] == 3'b000)
  `BCS_ASSERT_NEXT(a_port_zero, clk, rst, port_zero_read, result_valid && read_bits == 5'b00000)
  `BCS_ASSERT_NEXT(a_no_result, clk, rst, other_taken, !result_valid)
  `BCS_ASSERT_NEXT(a_result_hold, clk, rst, result_stalled, result_valid && $stable(read_bits))

endmodule

bind bike_controller_serializer_unit bcs_checker u_bcs_checker (.*);
